@@ src/i2c_register_read_sequencer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the I2C register read sequencer
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_READ_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_REGISTER_READ_SEQUENCER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/i2crrs_pkg.sv @@
// ----------------------------------------------------------------------------
// i2crrs_pkg
// Codes, widths and result type of the I2C register read sequencer.
// ----------------------------------------------------------------------------
package i2crrs_pkg;

    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int TAG_W   = 32;
    localparam int PHASE_W = 3;

    // bus event codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_NACK  = 2'd2;
    localparam logic [1:0] ACT_RX    = 2'd3;

    // sequence phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ADDR_WR = 3'd1;
    localparam logic [PHASE_W-1:0] PH_COMMAND = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ADDR_RD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HIGH    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LOW     = 3'd5;

    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    typedef struct packed {
        logic               issue_start;
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               send_ack;
        logic               send_nack_stop;
        logic               finished;
        logic [VALUE_W-1:0] read_value;
        logic [TAG_W-1:0]   finished_tag;
        logic               busy_res;
        logic               protocol_error;
    } t_result;

endpackage

@@ src/i2c_register_read_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_register_read_sequencer_unit
// I2C master sequencer for a two-byte register read, stepped by one bus
// event at a time.
//
// Input channel: i_in_valid / o_in_stall carries one bus event (start
// request with address, command and tag; ack; nack; received byte).
// Output channel: o_out_valid / i_out_stall carries one result per event:
// the bus commands to issue next, the finished value and tag, busy and
// error flags.
// An event is registered at acceptance in the input register, decoded
// against the phase register once the result register is free, and its
// result is registered in the result register, where it waits until taken.
// Throughput is one event per cycle while the output is not stalled.
// The input register moves on whenever the result register is empty or
// being taken, so an event is accepted while a result still waits; a
// stall on the output backs up into o_in_stall once both registers hold.
// Reset (i_rst_n low, synchronous) empties both registers, returns the
// phase to idle and clears the stored address, command, value and tag.
// ----------------------------------------------------------------------------
`include "i2c_register_read_sequencer_unit_assert.svh"

module i2c_register_read_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [i2crrs_pkg::ADDR_W-1:0] i_slave_address,
    input  logic [i2crrs_pkg::BYTE_W-1:0] i_register_command,
    input  logic [i2crrs_pkg::TAG_W-1:0]  i_completion_tag,
    input  logic [i2crrs_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_issue_start,
    output logic                          o_tx_valid,
    output logic [i2crrs_pkg::BYTE_W-1:0] o_tx_byte,
    output logic                          o_send_ack,
    output logic                          o_send_nack_stop,
    output logic                          o_finished,
    output logic [i2crrs_pkg::VALUE_W-1:0] o_read_value,
    output logic [i2crrs_pkg::TAG_W-1:0]  o_finished_tag,
    output logic                          o_busy_res,
    output logic                          o_protocol_error
);
    import i2crrs_pkg::*;

    // input register
    logic                r_in_valid;
    logic [1:0]          r_action;
    logic [ADDR_W-1:0]   r_slave_address;
    logic [BYTE_W-1:0]   r_register_command;
    logic [TAG_W-1:0]    r_completion_tag;
    logic [BYTE_W-1:0]   r_rx_byte;

    // sequence state
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [ADDR_W-1:0]   r_device_address, n_device_address;
    logic [BYTE_W-1:0]   r_command_byte, n_command_byte;
    logic [VALUE_W-1:0]  r_value_store, n_value_store;
    logic [TAG_W-1:0]    r_tag_store, n_tag_store;

    // result register
    logic                r_out_valid;
    t_result             r_res, n_res;

    logic w_move;     // input register may hand over to the result register
    logic w_process;  // event decoded and state updated this cycle
    logic w_in_accept;
    logic w_out_accept;

    assign w_move       = !r_out_valid || !i_out_stall;
    assign w_process    = r_in_valid && w_move;
    assign o_in_stall   = r_in_valid && !w_move;
    assign w_in_accept  = i_in_valid && !o_in_stall;
    assign w_out_accept = r_out_valid && !i_out_stall;

    always_comb begin
        n_phase          = r_phase;
        n_device_address = r_device_address;
        n_command_byte   = r_command_byte;
        n_value_store    = r_value_store;
        n_tag_store      = r_tag_store;
        n_res            = '0;

        case (r_action)
            ACT_START: begin
                if (r_phase == PH_IDLE) begin
                    n_device_address  = r_slave_address;
                    n_command_byte    = r_register_command;
                    n_tag_store       = r_completion_tag;
                    n_phase           = PH_ADDR_WR;
                    n_res.issue_start = 1'b1;
                    n_res.tx_valid    = 1'b1;
                    n_res.tx_byte     = {r_slave_address, RW_WRITE};
                end else begin
                    n_res.protocol_error = 1'b1;
                end
            end
            ACT_ACK: begin
                if (r_phase == PH_ADDR_WR) begin
                    n_phase        = PH_COMMAND;
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = r_command_byte;
                end else if (r_phase == PH_COMMAND) begin
                    n_phase           = PH_ADDR_RD;
                    n_res.issue_start = 1'b1;
                    n_res.tx_valid    = 1'b1;
                    n_res.tx_byte     = {r_device_address, RW_READ};
                end else if (r_phase == PH_ADDR_RD) begin
                    n_phase = PH_HIGH;
                end else begin
                    n_res.protocol_error = 1'b1;
                end
            end
            ACT_NACK: begin
                // device not ready: poll with the read address again
                if (r_phase == PH_ADDR_RD) begin
                    n_res.issue_start = 1'b1;
                    n_res.tx_valid    = 1'b1;
                    n_res.tx_byte     = {r_device_address, RW_READ};
                end else begin
                    n_res.protocol_error = 1'b1;
                end
            end
            default: begin
                if (r_phase == PH_HIGH) begin
                    n_value_store  = {r_rx_byte, {BYTE_W{1'b0}}};
                    n_phase        = PH_LOW;
                    n_res.send_ack = 1'b1;
                end else if (r_phase == PH_LOW) begin
                    n_value_store        = {r_value_store[VALUE_W-1:BYTE_W], r_rx_byte};
                    n_phase              = PH_IDLE;
                    n_res.send_nack_stop = 1'b1;
                    n_res.finished       = 1'b1;
                    n_res.read_value     = {r_value_store[VALUE_W-1:BYTE_W], r_rx_byte};
                    n_res.finished_tag   = r_tag_store;
                end else begin
                    n_res.protocol_error = 1'b1;
                end
            end
        endcase

        n_res.busy_res = (n_phase != PH_IDLE);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_action           <= i_action;
            r_slave_address    <= i_slave_address;
            r_register_command <= i_register_command;
            r_completion_tag   <= i_completion_tag;
            r_rx_byte          <= i_rx_byte;
        end
        if (w_process) begin
            r_res <= n_res;
        end
    end

    // control and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_phase          <= PH_IDLE;
            r_device_address <= '0;
            r_command_byte   <= '0;
            r_value_store    <= '0;
            r_tag_store      <= '0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_process) begin
                r_out_valid      <= 1'b1;
                r_phase          <= n_phase;
                r_device_address <= n_device_address;
                r_command_byte   <= n_command_byte;
                r_value_store    <= n_value_store;
                r_tag_store      <= n_tag_store;
            end else if (w_out_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_issue_start    = r_res.issue_start;
    assign o_tx_valid       = r_res.tx_valid;
    assign o_tx_byte        = r_res.tx_byte;
    assign o_send_ack       = r_res.send_ack;
    assign o_send_nack_stop = r_res.send_nack_stop;
    assign o_finished       = r_res.finished;
    assign o_read_value     = r_res.read_value;
    assign o_finished_tag   = r_res.finished_tag;
    assign o_busy_res       = r_res.busy_res;
    assign o_protocol_error = r_res.protocol_error;

    // a completed read always closes the bus and leaves the block idle
    `ASSERT_IMPLIES(a_finish_closes, i_clk, i_rst_n, o_out_valid && o_finished, o_send_nack_stop && !o_busy_res)
    // a rejected event leaves the phase untouched
    `ASSERT_NEXT(a_error_holds_phase, i_clk, i_rst_n, w_process && n_res.protocol_error, r_phase == $past(r_phase))
    // ack on the write address moves on to the command byte
    `ASSERT_NEXT(a_ack_to_command, i_clk, i_rst_n, w_process && r_action == ACT_ACK && r_phase == PH_ADDR_WR, r_phase == PH_COMMAND && o_tx_valid)

endmodule
